[rtl/bpd_pkg.sv]
package bpd_pkg;

    localparam int DateW    = 16;
    localparam int NcdW     = 17;
    localparam int PeriodW  = 9;
    localparam int AmtW     = 24;
    localparam int FactorW  = 24;
    localparam int SumW     = 40;
    localparam int ProdW    = AmtW + FactorW;
    localparam int FracDrop = 22;
    localparam int FlowW    = ProdW - FracDrop;
    localparam int RemW     = PeriodW + 1;
    localparam int DivSteps = NcdW;
    localparam int DivCntW  = $clog2(DivSteps);
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 24;

    // 100.0 in Q8.16
    localparam logic [AmtW-1:0]    PrincipalQ16 = AmtW'(6553600);
    localparam logic [ProdW-1:0]   RoundHalf    = ProdW'(1) << (FracDrop - 1);
    localparam logic [PeriodW-1:0] PeriodReset  = PeriodW'(365);
    localparam logic [DateW-1:0]   DayMax       = '1;

    typedef enum logic [CfgIdxW-1:0] {
        CfgStartDate    = 3'd0,
        CfgMaturityDate = 3'd1,
        CfgTodayDate    = 3'd2,
        CfgCouponPeriod = 3'd3,
        CfgCouponAmount = 3'd4
    } cfg_idx_t;

    typedef enum logic [3:0] {
        StIdle,
        StCheck,
        StDiv,
        StAlign,
        StEval,
        StMulCpn,
        StAddCpn,
        StMulPrn,
        StAddPrn,
        StFinish
    } state_t;

    typedef struct packed {
        logic [DateW-1:0]   start_date;
        logic [DateW-1:0]   maturity_date;
        logic [DateW-1:0]   today_date;
        logic [PeriodW-1:0] coupon_period_days;
        logic [AmtW-1:0]    coupon_amount;
    } cfg_t;

    // all terms zero except the coupon period
    localparam cfg_t CfgReset = '{
        start_date:         '0,
        maturity_date:      '0,
        today_date:         '0,
        coupon_period_days: PeriodReset,
        coupon_amount:      '0
    };

    typedef struct packed {
        logic [FactorW-1:0] discount_factor;
        logic [FactorW-1:0] bumped_discount_factor;
        logic               last_day;
    } item_t;

    typedef struct packed {
        logic [SumW-1:0]        price;
        logic signed [SumW-1:0] dv01;
        logic                   curve_short;
    } result_t;

    typedef struct packed {
        logic load;
        logic div_init;
        logic div_step;
        logic align_start;
        logic align_div;
        logic mul_cpn;
        logic mul_prn;
        logic acc;
        logic advance;
        logic set_fin;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic first;
        logic start_ge_today;
        logic div_last;
        logic hit;
        logic at_maturity;
    } stat_t;

endpackage

[rtl/bpd_ctrl.sv]
module bpd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  bpd_pkg::stat_t stat,
    output bpd_pkg::cmd_t  cmd,
    output logic           busy
);

    bpd_pkg::state_t state_reg;
    bpd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bpd_pkg::StIdle;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            bpd_pkg::StIdle:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = bpd_pkg::StCheck;
                end
            end
            bpd_pkg::StCheck:
            begin
                if (stat.finished)
                begin
                    state_next = bpd_pkg::StFinish;
                end
                else if (stat.first && stat.start_ge_today)
                begin
                    cmd.align_start = 1'b1;
                    state_next      = bpd_pkg::StEval;
                end
                else if (stat.first)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = bpd_pkg::StDiv;
                end
                else
                begin
                    state_next = bpd_pkg::StEval;
                end
            end
            bpd_pkg::StDiv:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = bpd_pkg::StAlign;
                end
            end
            bpd_pkg::StAlign:
            begin
                cmd.align_div = 1'b1;
                state_next    = bpd_pkg::StEval;
            end
            bpd_pkg::StEval:
            begin
                state_next = stat.hit ? bpd_pkg::StMulCpn : bpd_pkg::StFinish;
            end
            bpd_pkg::StMulCpn:
            begin
                cmd.mul_cpn = 1'b1;
                state_next  = bpd_pkg::StAddCpn;
            end
            bpd_pkg::StAddCpn:
            begin
                cmd.acc = 1'b1;
                if (stat.at_maturity)
                begin
                    state_next = bpd_pkg::StMulPrn;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next  = bpd_pkg::StFinish;
                end
            end
            bpd_pkg::StMulPrn:
            begin
                cmd.mul_prn = 1'b1;
                state_next  = bpd_pkg::StAddPrn;
            end
            bpd_pkg::StAddPrn:
            begin
                cmd.acc     = 1'b1;
                cmd.set_fin = 1'b1;
                state_next  = bpd_pkg::StFinish;
            end
            bpd_pkg::StFinish:
            begin
                cmd.finish = 1'b1;
                state_next = bpd_pkg::StIdle;
            end
            default:
            begin
                state_next = bpd_pkg::StIdle;
            end
        endcase
    end

endmodule

[rtl/bpd_datapath.sv]
module bpd_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  bpd_pkg::cfg_t    cfg,
    input  bpd_pkg::item_t   item,
    input  bpd_pkg::cmd_t    cmd,
    output bpd_pkg::stat_t   stat,
    output bpd_pkg::result_t result,
    output logic             done
);

    localparam int NcdW    = bpd_pkg::NcdW;
    localparam int SumW    = bpd_pkg::SumW;
    localparam int ProdW   = bpd_pkg::ProdW;
    localparam int RemW    = bpd_pkg::RemW;
    localparam int DivCntW = bpd_pkg::DivCntW;

    // control state
    logic [NcdW-1:0]           ncd_reg, ncd_next;
    logic [bpd_pkg::DateW-1:0] day_reg, day_next;
    logic [SumW-1:0]           price_reg, price_next;
    logic [SumW-1:0]           bump_reg, bump_next;
    logic                      fin_reg, fin_next;
    logic                      done_reg, done_next;
    logic [RemW-1:0]           rem_reg, rem_next;
    logic [NcdW-1:0]           divn_reg, divn_next;
    logic [DivCntW-1:0]        divcnt_reg, divcnt_next;

    // payload
    logic [bpd_pkg::FactorW-1:0] df_reg, df_next;
    logic [bpd_pkg::FactorW-1:0] bdf_reg, bdf_next;
    logic                        last_reg, last_next;
    logic                        finld_reg, finld_next;
    logic [ProdW-1:0]            proda_reg, proda_next;
    logic [ProdW-1:0]            prodb_reg, prodb_next;
    bpd_pkg::result_t            result_reg, result_next;

    logic [bpd_pkg::PeriodW-1:0] period;
    logic [NcdW-1:0]             cur_day;
    logic [bpd_pkg::AmtW-1:0]    mul_amt;
    logic [RemW-1:0]             trial;
    logic [RemW-1:0]             period_w;
    logic signed [SumW:0]        diff;
    logic signed [SumW-1:0]      dv01_sat;

    function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] a,
                                                input logic [ProdW-1:0] p);
        logic [ProdW-1:0] r;
        logic [SumW:0]    s;
        r = p + bpd_pkg::RoundHalf;
        s = {1'b0, a} + (SumW + 1)'(r[ProdW-1:bpd_pkg::FracDrop]);
        return s[SumW] ? '1 : s[SumW-1:0];
    endfunction

    // zero period runs as one day
    assign period   = (cfg.coupon_period_days == '0) ? bpd_pkg::PeriodW'(1)
                                                     : cfg.coupon_period_days;
    assign period_w = {1'b0, period};
    assign cur_day  = {1'b0, cfg.today_date} + {1'b0, day_reg};
    assign mul_amt  = cmd.mul_prn ? bpd_pkg::PrincipalQ16 : cfg.coupon_amount;
    assign trial    = {rem_reg[RemW-2:0], divn_reg[NcdW-1]};

    assign diff = $signed({1'b0, price_reg}) - $signed({1'b0, bump_reg});

    always_comb
    begin
        if (!diff[SumW] && diff[SumW-1])
        begin
            dv01_sat = {1'b0, {(SumW-1){1'b1}}};
        end
        else if (diff[SumW] && !diff[SumW-1])
        begin
            dv01_sat = {1'b1, {(SumW-1){1'b0}}};
        end
        else
        begin
            dv01_sat = diff[SumW-1:0];
        end
    end

    always_comb
    begin
        stat.finished       = fin_reg;
        stat.first          = (day_reg == '0);
        stat.start_ge_today = (cfg.start_date >= cfg.today_date);
        stat.div_last       = (divcnt_reg == DivCntW'(bpd_pkg::DivSteps - 1));
        stat.hit            = (day_reg != bpd_pkg::DayMax) && (cur_day == ncd_reg);
        stat.at_maturity    = (ncd_reg >= {1'b0, cfg.maturity_date});
    end

    always_comb
    begin
        ncd_next    = ncd_reg;
        day_next    = day_reg;
        price_next  = price_reg;
        bump_next   = bump_reg;
        fin_next    = fin_reg;
        done_next   = 1'b0;
        rem_next    = rem_reg;
        divn_next   = divn_reg;
        divcnt_next = divcnt_reg;
        df_next     = df_reg;
        bdf_next    = bdf_reg;
        last_next   = last_reg;
        finld_next  = finld_reg;
        proda_next  = proda_reg;
        prodb_next  = prodb_reg;
        result_next = result_reg;

        if (cmd.load)
        begin
            df_next    = item.discount_factor;
            bdf_next   = item.bumped_discount_factor;
            last_next  = item.last_day;
            finld_next = fin_reg;
        end

        if (cmd.align_start)
        begin
            ncd_next = {1'b0, cfg.start_date};
        end

        // ceil alignment: remainder of (today - start + p - 1) / p
        if (cmd.div_init)
        begin
            divn_next   = {1'b0, cfg.today_date} - {1'b0, cfg.start_date}
                        + NcdW'(period) - NcdW'(1);
            rem_next    = '0;
            divcnt_next = '0;
        end

        if (cmd.div_step)
        begin
            divn_next   = {divn_reg[NcdW-2:0], 1'b0};
            rem_next    = (trial >= period_w) ? trial - period_w : trial;
            divcnt_next = divcnt_reg + DivCntW'(1);
        end

        // start + k*p equals today + p - 1 - rem
        if (cmd.align_div)
        begin
            ncd_next = {1'b0, cfg.today_date} + NcdW'(period) - NcdW'(1)
                     - NcdW'(rem_reg);
        end

        if (cmd.mul_cpn || cmd.mul_prn)
        begin
            proda_next = ProdW'(mul_amt) * ProdW'(df_reg);
            prodb_next = ProdW'(mul_amt) * ProdW'(bdf_reg);
        end

        if (cmd.acc)
        begin
            price_next = sat_add(price_reg, proda_reg);
            bump_next  = sat_add(bump_reg, prodb_reg);
        end

        if (cmd.advance)
        begin
            ncd_next = ncd_reg + NcdW'(period);
        end

        if (cmd.set_fin)
        begin
            fin_next = 1'b1;
        end

        if (cmd.finish)
        begin
            if (!finld_reg)
            begin
                if (day_reg != bpd_pkg::DayMax)
                begin
                    day_next = day_reg + bpd_pkg::DateW'(1);
                end
                if (fin_reg || last_reg)
                begin
                    done_next               = 1'b1;
                    result_next.price       = price_reg;
                    result_next.dv01        = dv01_sat;
                    result_next.curve_short = !fin_reg;
                end
            end
            // end of stream rearms for the next one
            if (last_reg)
            begin
                day_next   = '0;
                price_next = '0;
                bump_next  = '0;
                fin_next   = 1'b0;
                ncd_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ncd_reg    <= '0;
            day_reg    <= '0;
            price_reg  <= '0;
            bump_reg   <= '0;
            fin_reg    <= 1'b0;
            done_reg   <= 1'b0;
            rem_reg    <= '0;
            divn_reg   <= '0;
            divcnt_reg <= '0;
        end
        else
        begin
            ncd_reg    <= ncd_next;
            day_reg    <= day_next;
            price_reg  <= price_next;
            bump_reg   <= bump_next;
            fin_reg    <= fin_next;
            done_reg   <= done_next;
            rem_reg    <= rem_next;
            divn_reg   <= divn_next;
            divcnt_reg <= divcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        df_reg     <= df_next;
        bdf_reg    <= bdf_next;
        last_reg   <= last_next;
        finld_reg  <= finld_next;
        proda_reg  <= proda_next;
        prodb_reg  <= prodb_next;
        result_reg <= result_next;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

[rtl/bond_price_dv01_accumulator.sv]
// Channel   | Ports                        | Transfer
// ----------+------------------------------+------------------------------------------
// request   | start, busy, item            | taken at clk edge with start & !busy
// result    | done, result                 | done high one cycle; no back-pressure
// config    | cfg_wr, cfg_idx, cfg_data    | written at clk edge with cfg_wr high
//
// busy stays high through the check, evaluate and finish states; a coupon day adds a
// coupon multiply and add, the maturity day a principal multiply and add too, and a
// paid-off bond goes from check to finish. A stream's first request with issue date
// before the valuation date adds the bit-serial remainder (17 steps) and alignment.
// rst_n clears state and config asynchronously; coupon_period_days resets to 365.
// done rises the cycle after the last busy cycle; the receiver cannot stall it.
module bond_price_dv01_accumulator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  bpd_pkg::item_t                 item,
    output logic                           done,
    output bpd_pkg::result_t               result,
    input  logic                           cfg_wr,
    input  logic [bpd_pkg::CfgIdxW-1:0]    cfg_idx,
    input  logic [bpd_pkg::CfgDataW-1:0]   cfg_data
);

    bpd_pkg::cfg_t  cfg_reg;
    bpd_pkg::cfg_t  cfg_next;
    bpd_pkg::cmd_t  cmd;
    bpd_pkg::stat_t stat;

    // Config registers: live values feed the datapath, alignment samples
    // them on the first request of a stream.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (cfg_idx)
                bpd_pkg::CfgStartDate:
                begin
                    cfg_next.start_date = cfg_data[bpd_pkg::DateW-1:0];
                end
                bpd_pkg::CfgMaturityDate:
                begin
                    cfg_next.maturity_date = cfg_data[bpd_pkg::DateW-1:0];
                end
                bpd_pkg::CfgTodayDate:
                begin
                    cfg_next.today_date = cfg_data[bpd_pkg::DateW-1:0];
                end
                bpd_pkg::CfgCouponPeriod:
                begin
                    cfg_next.coupon_period_days = cfg_data[bpd_pkg::PeriodW-1:0];
                end
                bpd_pkg::CfgCouponAmount:
                begin
                    cfg_next.coupon_amount = cfg_data[bpd_pkg::AmtW-1:0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= bpd_pkg::CfgReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: one state per step of a request.
    bpd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Accumulators, coupon-date tracking, remainder unit, multipliers.
    bpd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result),
        .done   (done)
    );

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    // Run shape
    localparam int DrainCycles = 40;      // longer than the worst request (remainder unit + maturity)
    localparam int CycleLimit  = 500_000; // several times the slowest legal run
    localparam int RandomItems = 1000;
    localparam int QuietTail   = 150;     // last random requests go back to back
    localparam int StreamCap   = 120;     // longest random curve, in days
    localparam int DailyStream = 64;      // coupon every day, maturity out of reach

    // Q24.16 accumulator ceiling and signed Q23.16 dv01 limits
    localparam logic [63:0] SumMax = 64'hFF_FFFF_FFFF;
    localparam longint      DvMax  = 64'sh7F_FFFF_FFFF;
    localparam longint      DvMin  = -64'sh80_0000_0000;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    bpd_pkg::item_t               item;
    logic                         done;
    bpd_pkg::result_t             result;
    logic                         cfg_wr;
    logic [bpd_pkg::CfgIdxW-1:0]  cfg_idx;
    logic [bpd_pkg::CfgDataW-1:0] cfg_data;

    // ------------------------------------------------------------------
    // Bond pricer: shadow copy of the terms and of the running sums. Each
    // accepted day is priced here; a finished (or cut short) bond queues
    // the quote it must produce on pending_quotes.
    // ------------------------------------------------------------------
    class bond_pricer;
        logic [bpd_pkg::DateW-1:0]   start_day;
        logic [bpd_pkg::DateW-1:0]   maturity_day;
        logic [bpd_pkg::DateW-1:0]   today_day;
        logic [bpd_pkg::PeriodW-1:0] period_days;
        logic [bpd_pkg::AmtW-1:0]    cpn_amount;

        logic [63:0]                 next_cpn;
        logic [bpd_pkg::DateW-1:0]   day_count;
        logic [bpd_pkg::SumW-1:0]    price_acc;
        logic [bpd_pkg::SumW-1:0]    bumped_acc;
        bit                          paid_off;

        bpd_pkg::result_t            pending_quotes[$];
        int                          mismatches;
        int                          quotes_seen;
        int                          short_quotes;

        function new();
            start_day    = '0;
            maturity_day = '0;
            today_day    = '0;
            period_days  = bpd_pkg::PeriodReset;
            cpn_amount   = '0;
            mismatches   = 0;
            quotes_seen  = 0;
            short_quotes = 0;
            clear_stream();
        endfunction

        // last_day seen: next request opens a new curve
        function void clear_stream();
            next_cpn   = '0;
            day_count  = '0;
            price_acc  = '0;
            bumped_acc = '0;
            paid_off   = 1'b0;
        endfunction

        function void write_reg(bpd_pkg::cfg_idx_t idx, logic [bpd_pkg::CfgDataW-1:0] val);
            case (idx)
                bpd_pkg::CfgStartDate:    start_day    = val[bpd_pkg::DateW-1:0];
                bpd_pkg::CfgMaturityDate: maturity_day = val[bpd_pkg::DateW-1:0];
                bpd_pkg::CfgTodayDate:    today_day    = val[bpd_pkg::DateW-1:0];
                bpd_pkg::CfgCouponPeriod: period_days  = val[bpd_pkg::PeriodW-1:0];
                bpd_pkg::CfgCouponAmount: cpn_amount   = val[bpd_pkg::AmtW-1:0];
                default: ;
            endcase
        endfunction

        // Q8.16 * Q2.22, rounded half up back to Q.16
        function logic [63:0] cash_flow(logic [bpd_pkg::AmtW-1:0] amt,
                                        logic [bpd_pkg::FactorW-1:0] f);
            return (64'(amt) * 64'(f) + (64'd1 << 21)) >> 22;
        endfunction

        function logic [bpd_pkg::SumW-1:0] acc_sat(logic [bpd_pkg::SumW-1:0] a,
                                                   logic [63:0] b);
            logic [63:0] s;
            s = 64'(a) + b;
            return (s > SumMax) ? SumMax[bpd_pkg::SumW-1:0] : s[bpd_pkg::SumW-1:0];
        endfunction

        function bpd_pkg::result_t quote(bit short_curve);
            bpd_pkg::result_t q;
            longint           diff;
            diff = longint'({24'd0, price_acc}) - longint'({24'd0, bumped_acc});
            if (diff > DvMax) diff = DvMax;
            if (diff < DvMin) diff = DvMin;
            q.price       = price_acc;
            q.dv01        = diff[bpd_pkg::SumW-1:0];
            q.curve_short = short_curve;
            return q;
        endfunction

        function void expect_quote(bit short_curve);
            pending_quotes = {pending_quotes, quote(short_curve)};
        endfunction

        function void price_day(bpd_pkg::item_t d);
            logic [63:0] p;
            logic [63:0] k;
            logic [63:0] cur;
            if (!paid_off)
            begin
                p = (period_days == '0) ? 64'd1 : 64'(period_days);
                // first day of a curve: roll the coupon date up to today
                if (day_count == '0)
                begin
                    if (start_day >= today_day)
                    begin
                        next_cpn = 64'(start_day);
                    end
                    else
                    begin
                        k = (64'(today_day) - 64'(start_day) + p - 1) / p;
                        next_cpn = 64'(start_day) + k * p;
                    end
                end
                cur = 64'(today_day) + 64'(day_count);
                // a saturated day counter never lands on a coupon date
                if (day_count != bpd_pkg::DayMax && cur == next_cpn)
                begin
                    price_acc  = acc_sat(price_acc, cash_flow(cpn_amount, d.discount_factor));
                    bumped_acc = acc_sat(bumped_acc,
                                         cash_flow(cpn_amount, d.bumped_discount_factor));
                    if (next_cpn >= 64'(maturity_day))
                    begin
                        price_acc  = acc_sat(price_acc,
                                             cash_flow(bpd_pkg::PrincipalQ16,
                                                       d.discount_factor));
                        bumped_acc = acc_sat(bumped_acc,
                                             cash_flow(bpd_pkg::PrincipalQ16,
                                                       d.bumped_discount_factor));
                        paid_off = 1'b1;
                        expect_quote(1'b0);
                    end
                    else
                    begin
                        next_cpn = (next_cpn + p) & 64'h1_FFFF;
                    end
                end
                if (day_count != bpd_pkg::DayMax) day_count++;
                // curve ran out before the final coupon: partial sums, flagged short
                if (d.last_day && !paid_off) expect_quote(1'b1);
            end
            if (d.last_day) clear_stream();
        endfunction

        function void check_quote(bpd_pkg::result_t got);
            bpd_pkg::result_t want;
            quotes_seen++;
            if (got.curve_short) short_quotes++;
            if (pending_quotes.size() == 0)
            begin
                $display("%0t: quote expected none actual price %h dv01 %h short %b",
                         $time, got.price, got.dv01, got.curve_short);
                mismatches++;
                return;
            end
            want = pending_quotes.pop_front();
            if (got.price !== want.price)
            begin
                $display("%0t: price expected %h actual %h", $time, want.price, got.price);
                mismatches++;
            end
            if (got.dv01 !== want.dv01)
            begin
                $display("%0t: dv01 expected %h actual %h", $time, want.dv01, got.dv01);
                mismatches++;
            end
            if (got.curve_short !== want.curve_short)
            begin
                $display("%0t: curve_short expected %b actual %b",
                         $time, want.curve_short, got.curve_short);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_quotes.size();
        endfunction
    endclass

    bond_pricer book = new();
    int         sent;       // requests accepted so far
    int         term_sets;  // bond term sets loaded
    bit         idle_on;    // random gaps between requests

    bond_price_dv01_accumulator dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .cfg_wr   (cfg_wr),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // hang guard
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    // done is a one-cycle strobe; sampled on the edge that closes it
    always @(posedge clk)
    begin
        if (rst_n && done) book.check_quote(result);
    end

    // ------------------------------------------------------------------
    // Drivers. Every task is entered just after a rising edge.
    // ------------------------------------------------------------------
    function automatic logic [bpd_pkg::FactorW-1:0] pick_factor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 24'h40_0000 - 24'($urandom_range(0, 65535));  // near 1.0
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic bpd_pkg::item_t make_day(logic [bpd_pkg::FactorW-1:0] f,
                                                logic [bpd_pkg::FactorW-1:0] b,
                                                logic last);
        bpd_pkg::item_t d;
        d.discount_factor        = f;
        d.bumped_discount_factor = b;
        d.last_day               = last;
        return d;
    endfunction

    // value in the low w bits, sometimes junk above (the register keeps w bits)
    function automatic logic [bpd_pkg::CfgDataW-1:0] pad(int v, int w);
        logic [bpd_pkg::CfgDataW-1:0] junk;
        junk = ($urandom_range(0, 3) == 0) ? bpd_pkg::CfgDataW'($urandom) : '0;
        return (junk << w) | (bpd_pkg::CfgDataW'(v)
                              & ((bpd_pkg::CfgDataW'(1) << w) - 1));
    endfunction

    // leaves cfg_wr high so back-to-back writes need one assignment per edge
    task automatic put_reg(input bpd_pkg::cfg_idx_t idx,
                           input logic [bpd_pkg::CfgDataW-1:0] val);
        cfg_wr   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        book.write_reg(idx, val);
    endtask

    task automatic load_terms(input logic [bpd_pkg::CfgDataW-1:0] s,
                              input logic [bpd_pkg::CfgDataW-1:0] m,
                              input logic [bpd_pkg::CfgDataW-1:0] t,
                              input logic [bpd_pkg::CfgDataW-1:0] p,
                              input logic [bpd_pkg::CfgDataW-1:0] a);
        put_reg(bpd_pkg::CfgStartDate, s);
        put_reg(bpd_pkg::CfgMaturityDate, m);
        put_reg(bpd_pkg::CfgTodayDate, t);
        put_reg(bpd_pkg::CfgCouponPeriod, p);
        put_reg(bpd_pkg::CfgCouponAmount, a);
        cfg_wr <= 1'b0;
        term_sets++;
    endtask

    // one request; start stays high afterwards until the next request or settle
    task automatic send_day(input bpd_pkg::item_t d);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= d;
        do @(posedge clk); while (busy);
        book.price_day(d);
        sent++;
    endtask

    // drop start, wait out all quotes, then let the last accepted request finish
    task automatic settle();
        start <= 1'b0;
        while (book.pending() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // One curve. Mostly runs to maturity plus a few ignored days, then last_day;
    // cut_short ends it at a random day instead.
    task automatic run_stream(input int max_days, input bit cut_short);
        int  n;
        int  cut;
        int  trail;
        bit  stop;
        cut   = $urandom_range(0, max_days - 1);
        trail = $urandom_range(0, 3);
        n     = 0;
        stop  = 1'b0;
        while (!stop)
        begin
            if (book.paid_off)
            begin
                if (trail == 0) stop = 1'b1;
                else trail--;
            end
            if ((cut_short && n == cut) || n == max_days - 1) stop = 1'b1;
            send_day(make_day(pick_factor(), pick_factor(), stop));
            n++;
        end
    endtask

    initial
    begin
        int                           base;
        int                           praw;
        int                           pe;
        int                           today;
        int                           off;
        int                           k;
        int                           sd;
        int                           md;
        logic [bpd_pkg::CfgDataW-1:0] amt;

        rst_n     = 1'b0;
        start     = 1'b0;
        item      = '0;
        cfg_wr    = 1'b0;
        cfg_idx   = bpd_pkg::CfgStartDate;
        cfg_data  = '0;
        sent      = 0;
        term_sets = 0;
        idle_on   = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset terms: all dates 0, period 365, zero coupon -> principal only on
        // day one; then an ignored day after pricing and the closing day.
        send_day(make_day('1, '1, 1'b0));
        send_day(make_day('0, '0, 1'b0));
        send_day(make_day(pick_factor(), pick_factor(), 1'b1));
        settle();

        // Zero period (acts as one day), extreme dates, full coupon: pays and
        // closes on the same request.
        load_terms(pad(0, 16), pad(65535, 16), pad(65535, 16), pad(0, 9), '1);
        send_day(make_day('1, '0, 1'b1));
        settle();

        // Oversized period: issue 511 days before the first coupon, today 3 days
        // short of it; zero base factor vs full bumped gives a negative dv01.
        load_terms(bpd_pkg::CfgDataW'(1000), bpd_pkg::CfgDataW'(1511),
                   bpd_pkg::CfgDataW'(1508), bpd_pkg::CfgDataW'(511), 24'h0A_0000);
        repeat (3) send_day(make_day(pick_factor(), pick_factor(), 1'b0));
        send_day(make_day('0, '1, 1'b0));
        send_day(make_day(pick_factor(), pick_factor(), 1'b1));
        settle();

        // Issue after today; coupon changed mid-curve; curve ends short.
        load_terms(bpd_pkg::CfgDataW'(12), bpd_pkg::CfgDataW'(30),
                   bpd_pkg::CfgDataW'(10), bpd_pkg::CfgDataW'(2), 24'h12_3456);
        repeat (3) send_day(make_day(pick_factor(), pick_factor(), 1'b0));
        settle();
        put_reg(bpd_pkg::CfgCouponAmount, 24'hFE_DCBA);
        cfg_wr <= 1'b0;
        repeat (2) send_day(make_day(pick_factor(), pick_factor(), 1'b0));
        send_day(make_day(pick_factor(), pick_factor(), 1'b1));
        settle();

        // Plain bond: coupons every 3 days, maturity on the second, two ignored days.
        load_terms(bpd_pkg::CfgDataW'(100), bpd_pkg::CfgDataW'(106),
                   bpd_pkg::CfgDataW'(101), bpd_pkg::CfgDataW'(3),
                   bpd_pkg::CfgDataW'($urandom));
        for (int i = 0; i < 9; i++)
            send_day(make_day(pick_factor(), pick_factor(), i == 8));
        settle();

        // A coupon every day from day 0 with the maturity out of reach, back to
        // back; the curve is reported short.
        idle_on = 1'b0;
        load_terms('0, bpd_pkg::CfgDataW'(65535), '0, '0, '1);
        for (int i = 0; i < DailyStream; i++)
            send_day(make_day('1, bpd_pkg::FactorW'($urandom_range(0, 1 << 20)),
                              i == DailyStream - 1));
        settle();

        // Random bonds; most curves run to maturity, some are cut short.
        idle_on = 1'b1;
        base = sent;
        while (sent - base < RandomItems)
        begin
            if (sent - base > RandomItems - QuietTail) idle_on = 1'b0;
            else idle_on = ($urandom_range(0, 3) != 0);

            case ($urandom_range(0, 9))
                0:       praw = 0;
                1:       praw = $urandom_range(367, 511);
                2:       praw = $urandom_range(31, 366);
                default: praw = $urandom_range(1, 30);
            endcase
            pe    = (praw == 0) ? 1 : praw;
            today = $urandom_range(0, 65535);
            off   = $urandom_range(0, (pe - 1 < 30) ? pe - 1 : 30);
            k     = $urandom_range(0, 3);
            // first coupon lands "off" days after today
            sd    = today + off - k * pe;
            if (sd < 0) sd = 0;
            if ($urandom_range(0, 7) == 0) sd = $urandom_range(0, 65535);
            md = today + off - $urandom_range(0, 4);
            if (pe <= 30) md += $urandom_range(0, 3) * pe;
            case ($urandom_range(0, 7))
                0:       md = $urandom_range(0, 65535);
                1:       md = today - $urandom_range(0, 500);
                default: ;
            endcase
            if (md < 0) md = 0;
            if (md > 65535) md = 65535;
            if (sd > 65535) sd = 65535;
            case ($urandom_range(0, 7))
                0:       amt = '0;
                1:       amt = 24'hFF_FFFF;
                default: amt = bpd_pkg::CfgDataW'($urandom);
            endcase

            load_terms(pad(sd, 16), pad(md, 16), pad(today, 16), pad(praw, 9), amt);
            repeat ($urandom_range(1, 4)) run_stream(StreamCap, $urandom_range(0, 4) == 0);
            settle();
        end

        $display("%0d requests over %0d bond term sets; %0d quotes checked, %0d short",
                 sent, term_sets, book.quotes_seen, book.short_quotes);
        if (book.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

[bond_price_dv01_accumulator.f]
rtl/bpd_pkg.sv
rtl/bpd_ctrl.sv
rtl/bpd_datapath.sv
rtl/bond_price_dv01_accumulator.sv
sim/tb_top.sv
